### rtl/sbpd_pkg.sv
// shared types and constants for the seven-bit packet deframer with link watch
// no dependencies; imported by sbpd_gather and the top level
`default_nettype none

package sbpd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SYM_W       = 7;
  localparam int unsigned WORD_W      = 2 * SYM_W;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned PAYLOAD_LEN = 13;
  localparam int unsigned STORE_DEPTH = PAYLOAD_LEN - 1;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned STORE_IDX_W = 4;
  localparam int unsigned SILENCE_W   = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [INDEX_W-1:0] IDX_HUNT = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] IDX_LAST = INDEX_W'(PAYLOAD_LEN);

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [BYTE_W-1:0]    START_MARKER_RESET = 8'd128;
  localparam logic [SILENCE_W-1:0] TIMEOUT_RESET      = 16'd1000;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX        = 16'hFFFF;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } sbpd_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]      ball_angle;
    logic [WORD_W-1:0]      ball_strength;
    logic [WORD_W-1:0]      heading;
    logic                   ball_out;
    logic [SYM_W-1:0]       play_mode;
    logic                   on_field;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } sbpd_fields_t;

  typedef struct packed {
    logic                    frame_done;
    logic                    connected;
    logic [WORD_W-1:0]       ball_angle;
    logic [WORD_W-1:0]       ball_strength;
    logic [WORD_W-1:0]       heading;
    logic                    ball_out;
    logic [SYM_W-1:0]        play_mode;
    logic                    on_field;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } sbpd_out_t;

  // completed frame report from the gather stage
  typedef struct packed {
    logic         done;
    sbpd_fields_t fields;
  } sbpd_frame_t;

endpackage

`default_nettype wire

### rtl/sbpd_gather.sv
// marker hunt, payload byte store and frame decode
// depends on sbpd_pkg
`default_nettype none

module sbpd_gather
  import sbpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire sbpd_in_t          item,
  input  wire logic [BYTE_W-1:0] start_marker,
  output sbpd_frame_t            frame
);

  logic [INDEX_W-1:0]     byte_index;
  logic [INDEX_W-1:0]     byte_index_next;
  logic [SYM_W-1:0]       payload_store [STORE_DEPTH];
  logic [STORE_IDX_W-1:0] wr_idx;
  logic                   wr_en;
  logic                   is_byte;
  logic [SYM_W-1:0]       sym;

  assign is_byte = step && (item.action == ACT_BYTE);
  assign sym     = item.rx_byte[SYM_W-1:0];
  assign wr_idx  = STORE_IDX_W'(byte_index - INDEX_W'(1));
  assign wr_en   = is_byte && (byte_index != IDX_HUNT) && (byte_index != IDX_LAST);

  always_comb begin
    byte_index_next = byte_index;
    if (is_byte) begin
      if (byte_index == IDX_HUNT) begin
        if (item.rx_byte == start_marker) byte_index_next = INDEX_W'(1);
      end else if (byte_index == IDX_LAST) begin
        byte_index_next = IDX_HUNT;
      end else begin
        byte_index_next = byte_index + INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= IDX_HUNT;
    end else begin
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) payload_store[wr_idx] <= sym;
  end

  // the last payload byte comes straight from the input, the rest from the store
  always_comb begin
    frame.done                 = is_byte && (byte_index == IDX_LAST);
    frame.fields.ball_angle    = {payload_store[0], payload_store[1]};
    frame.fields.ball_strength = {payload_store[2], payload_store[3]};
    frame.fields.heading       = {payload_store[4], payload_store[5]};
    frame.fields.ball_out      = (payload_store[6] != '0);
    frame.fields.play_mode     = payload_store[7];
    frame.fields.on_field      = (payload_store[8] != '0);
    frame.fields.pos_x         = {payload_store[9][0], payload_store[10]};
    frame.fields.pos_y         = {payload_store[11][0], sym};
  end

endmodule

`default_nettype wire

### rtl/seven_bit_packet_deframer_link_watch.sv
// top level: seven-bit packet deframer with link watch
// Channels: in_valid/in_stall/in_data carries one received byte (action 0) or one
// time tick (action 1) per transfer; out_valid/out_stall/out_data returns exactly one
// result per input transfer, in order. cfg_we/cfg_index/cfg_data write start_marker
// (index 0) and timeout_ticks (index 1) in the cycle cfg_we is high.
// While hunting, bytes are dropped until one equals start_marker; the next 13 bytes
// form a frame, low 7 bits each. The completing byte decodes the frame and clears the
// silence counter; ticks count silence up to saturation. Data read as zero while the
// link is down.
// The result register holds the result in the cycle after the input
// transfer. Throughput is one item per cycle, set by the single result register; a new
// item is taken whenever that register is empty or is being emptied.
// If the receiver stalls, the result holds and in_stall rises the same cycle, so no
// more input is taken until the result moves.
// Reset (rst, synchronous) restores both registers to 128 and 1000, starts hunting,
// sets the silence counter to 1000 (link down) and clears the decoded data.
// Depends on sbpd_pkg and sbpd_gather.
`default_nettype none

module seven_bit_packet_deframer_link_watch
  import sbpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sbpd_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sbpd_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BYTE_W-1:0]    start_marker;
  logic [SILENCE_W-1:0] timeout_ticks;
  logic [SILENCE_W-1:0] silence_count;
  logic [SILENCE_W-1:0] silence_count_next;
  sbpd_fields_t         decoded;
  sbpd_fields_t         decoded_next;
  sbpd_frame_t          frame;
  logic                 accept;
  logic                 conn;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker  <= START_MARKER_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_MARKER:  start_marker  <= cfg_data[BYTE_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[SILENCE_W-1:0];
        default:           ;
      endcase
    end
  end

  sbpd_gather u_gather (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .item         (in_data),
    .start_marker (start_marker),
    .frame        (frame)
  );

  always_comb begin
    silence_count_next = silence_count;
    if (in_data.action == ACT_TICK) begin
      if (silence_count != SILENCE_MAX) silence_count_next = silence_count + SILENCE_W'(1);
    end else if (frame.done) begin
      silence_count_next = '0;
    end
    conn = frame.done || (silence_count_next < timeout_ticks);
    // link loss clears the stored data itself
    if (!conn) begin
      decoded_next = '0;
    end else if (frame.done) begin
      decoded_next = frame.fields;
    end else begin
      decoded_next = decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_count <= TIMEOUT_RESET;
      decoded       <= '0;
    end else if (accept) begin
      silence_count <= silence_count_next;
      decoded       <= decoded_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.frame_done    <= frame.done;
      out_data.connected     <= conn;
      out_data.ball_angle    <= decoded_next.ball_angle;
      out_data.ball_strength <= decoded_next.ball_strength;
      out_data.heading       <= decoded_next.heading;
      out_data.ball_out      <= decoded_next.ball_out;
      out_data.play_mode     <= decoded_next.play_mode;
      out_data.on_field      <= decoded_next.on_field;
      out_data.pos_x         <= decoded_next.pos_x;
      out_data.pos_y         <= decoded_next.pos_y;
    end
  end

  a_done_connected: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.connected)
    else $error("completed frame reported without link");

  a_down_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.connected |->
      (out_data.ball_angle == '0) && (out_data.ball_strength == '0) &&
      (out_data.heading == '0) && !out_data.ball_out && (out_data.play_mode == '0) &&
      !out_data.on_field && (out_data.pos_x == '0) && (out_data.pos_y == '0))
    else $error("data not cleared while link is down");

  a_frame_clears_silence: assert property (@(posedge clk) disable iff (rst)
    accept && frame.done |=> silence_count == '0)
    else $error("silence counter not cleared by frame");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("input transfer without result");

endmodule

`default_nettype wire

### tb/tb_seven_bit_packet_deframer_link_watch.sv
// testbench for seven_bit_packet_deframer_link_watch: directed and random byte/tick traffic,
// each result compared against an in-bench deframer and link-watch predictor
// depends on sbpd_pkg and the rtl top level only

module tb_seven_bit_packet_deframer_link_watch;
  import sbpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 950;

  typedef logic [PAYLOAD_LEN-1:0][BYTE_W-1:0] frame_bytes_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sbpd_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sbpd_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_START_MARKER;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [BYTE_W-1:0]    marker_reg = START_MARKER_RESET;
  logic [SILENCE_W-1:0] timeout_reg = TIMEOUT_RESET;
  logic [INDEX_W-1:0]   frame_pos = IDX_HUNT;
  logic [SYM_W-1:0]     sym_store [STORE_DEPTH];
  sbpd_fields_t         held_fields = '0;
  logic [SILENCE_W-1:0] silence_ticks = TIMEOUT_RESET;

  sbpd_out_t link_reports [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  int        hold_request = 0;
  bit        result_taken = 1'b0;
  bit        tx_idle_on = 1'b1;
  bit        rx_idle_on = 1'b1;

  seven_bit_packet_deframer_link_watch u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic sbpd_out_t deframe_step(sbpd_in_t item);
    sbpd_out_t r;
    logic      done;
    logic      conn;
    int        slot;
    done = 1'b0;
    if (item.action == ACT_TICK) begin
      if (silence_ticks != SILENCE_MAX) silence_ticks++;
    end else if (frame_pos == IDX_HUNT) begin
      if (item.rx_byte == marker_reg) frame_pos = IDX_HUNT + 1'b1;
    end else if (frame_pos != IDX_LAST) begin
      slot = int'(frame_pos) - 1;
      sym_store[slot] = item.rx_byte[SYM_W-1:0];
      frame_pos++;
    end else begin
      held_fields.ball_angle    = {sym_store[0], sym_store[1]};
      held_fields.ball_strength = {sym_store[2], sym_store[3]};
      held_fields.heading       = {sym_store[4], sym_store[5]};
      held_fields.ball_out      = (sym_store[6] != '0);
      held_fields.play_mode     = sym_store[7];
      held_fields.on_field      = (sym_store[8] != '0);
      // positions keep only the low 8 bits of the 14-bit pair
      held_fields.pos_x         = {sym_store[9][0], sym_store[10]};
      held_fields.pos_y         = {sym_store[11][0], item.rx_byte[SYM_W-1:0]};
      frame_pos     = IDX_HUNT;
      silence_ticks = '0;
      done          = 1'b1;
    end
    conn = done || (silence_ticks < timeout_reg);
    if (!conn) held_fields = '0;
    r.frame_done    = done;
    r.connected     = conn;
    r.ball_angle    = held_fields.ball_angle;
    r.ball_strength = held_fields.ball_strength;
    r.heading       = held_fields.heading;
    r.ball_out      = held_fields.ball_out;
    r.play_mode     = held_fields.play_mode;
    r.on_field      = held_fields.on_field;
    r.pos_x         = held_fields.pos_x;
    r.pos_y         = held_fields.pos_y;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result side: compare in the half cycle before the transfer edge
  always @(negedge clk) begin : result_check
    sbpd_out_t want;
    if (!rst && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (link_reports.size() == 0) begin
        $error("result transfer with no report pending");
        mismatches++;
      end else begin
        want = link_reports.pop_front();
        check_field("frame_done", 16'(want.frame_done), 16'(out_data.frame_done));
        check_field("connected", 16'(want.connected), 16'(out_data.connected));
        check_field("ball_angle", 16'(want.ball_angle), 16'(out_data.ball_angle));
        check_field("ball_strength", 16'(want.ball_strength), 16'(out_data.ball_strength));
        check_field("heading", 16'(want.heading), 16'(out_data.heading));
        check_field("ball_out", 16'(want.ball_out), 16'(out_data.ball_out));
        check_field("play_mode", 16'(want.play_mode), 16'(out_data.play_mode));
        check_field("on_field", 16'(want.on_field), 16'(out_data.on_field));
        check_field("pos_x", 16'(unsigned'(want.pos_x)), 16'(unsigned'(out_data.pos_x)));
        check_field("pos_y", 16'(unsigned'(want.pos_y)), 16'(unsigned'(out_data.pos_y)));
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int wait_left;
    int hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (result_taken) begin
        result_taken = 1'b0;
        wait_left = rx_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input sbpd_in_t item);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (in_stall);
    link_reports.push_back(deframe_step(item));
    items_sent++;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    sbpd_in_t item;
    item.action  = ACT_BYTE;
    item.rx_byte = value;
    send_item(item);
  endtask

  task automatic send_tick();
    sbpd_in_t item;
    item.action  = ACT_TICK;
    item.rx_byte = BYTE_W'($urandom_range(0, 255));
    send_item(item);
  endtask

  // marker then 13 payload bytes, with a tick now and then when tick_odds is nonzero
  task automatic send_frame(input frame_bytes_t body, input int tick_odds);
    send_byte(marker_reg);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (tick_odds > 0 && $urandom_range(0, tick_odds - 1) == 0) send_tick();
      send_byte(body[i]);
    end
  endtask

  function automatic frame_bytes_t random_body();
    frame_bytes_t b;
    for (int i = 0; i < PAYLOAD_LEN; i++) b[i] = BYTE_W'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (link_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_link(input logic [BYTE_W-1:0] mk, input logic [SILENCE_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data  <= CFG_DATA_W'(mk);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker_reg  = mk;
    timeout_reg = ticks;
  endtask

  // reset values, an all-ones payload, marker as payload, ticks mid frame
  task automatic test_directed_frames();
    frame_bytes_t body;
    send_tick();
    send_byte(8'h00);
    body = {PAYLOAD_LEN{8'hFF}};
    send_byte(marker_reg);
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (i == 5) send_tick();
      send_byte(body[i]);
    end
    // marker bytes inside the payload are plain data; positions hit -128
    body = {PAYLOAD_LEN{START_MARKER_RESET}};
    body[9]  = 8'h01;
    body[11] = 8'h81;
    send_frame(body, 0);
    drain();
  endtask

  task automatic test_link_loss();
    set_link(START_MARKER_RESET, 16'd1);
    send_frame(random_body(), 0);
    send_tick();
    drain();
    // data stay cleared when the timeout is raised again
    set_link(START_MARKER_RESET, SILENCE_MAX);
    send_byte(8'h3C);
    send_tick();
    drain();
    set_link(START_MARKER_RESET, 16'd3);
    send_frame(random_body(), 0);
    repeat (4) send_tick();
    send_frame(random_body(), 4);
    drain();
  endtask

  task automatic test_marker_extremes();
    set_link(8'h00, 16'd50);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_frame(random_body(), 0);
    drain();
    set_link(8'hFF, 16'd50);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_frame(random_body(), 6);
    drain();
  endtask

  // no gaps on either side; link lost on ticks and regained by the next frame
  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_link(START_MARKER_RESET, 16'd10);
    send_frame(random_body(), 3);
    repeat (12) send_tick();
    send_frame(random_body(), 0);
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_input_backpressure();
    set_link(8'h5A, 16'd20);
    tx_idle_on   = 1'b0;
    hold_request = 300;
    send_frame(random_body(), 5);
    repeat (6) send_tick();
    send_frame(random_body(), 5);
    drain();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                   stop_at;
    int                   next_phase;
    int                   pick;
    logic [BYTE_W-1:0]    mk;
    logic [SILENCE_W-1:0] ticks;
    stop_at    = items_sent + RANDOM_ITEMS;
    next_phase = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_phase) begin
        drain();
        case ($urandom_range(0, 3))
          0:       mk = 8'h00;
          1:       mk = 8'hFF;
          default: mk = BYTE_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0:       ticks = 16'd1;
          1:       ticks = SILENCE_MAX;
          default: ticks = SILENCE_W'($urandom_range(2, 40));
        endcase
        set_link(mk, ticks);
        next_phase = items_sent + 250;
      end
      if ($urandom_range(0, 14) == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 14) == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick <= 2) begin
        repeat ($urandom_range(1, 4)) send_tick();
      end else if (pick == 3) begin
        // cut-off frame: the next bytes finish it out of step
        send_byte(marker_reg);
        repeat ($urandom_range(1, 12)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_frame(random_body(), 8);
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_link_loss();
    test_marker_extremes();
    test_back_to_back();
    test_input_backpressure();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && link_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sbpd_pkg.sv
rtl/sbpd_gather.sv
rtl/seven_bit_packet_deframer_link_watch.sv
tb/tb_seven_bit_packet_deframer_link_watch.sv
